@@ src/ghd_pkg.sv @@
// ---------------------------------------------------------------------------
// GIOP header deframer package
// Shared types, register indexes and header constants.
// ---------------------------------------------------------------------------
`default_nettype none

package ghd_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TDATA_W    = 88;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_MINOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRICT    = 8'd1;

  localparam logic [3:0][7:0] MAGIC      = {8'h50, 8'h4F, 8'h49, 8'h47};
  localparam logic [7:0]      GIOP_MAJOR = 8'h01;
  localparam logic [7:0]      FRAG_MINOR = 8'h02;
  localparam logic [7:0]      FLAG_RSVD  = 8'hFC;
  localparam logic [3:0]      HDR_LAST   = 4'd11;
  localparam logic [3:0]      ID_BYTES   = 4'd4;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_REQID   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_HDR_OK      = 3'd0,
    EV_MSG_END     = 3'd1,
    EV_BAD_MAGIC   = 3'd2,
    EV_BAD_VERSION = 3'd3,
    EV_BAD_FLAGS   = 3'd4,
    EV_REQ_ID      = 3'd5
  } event_t;

  typedef struct packed {
    logic [7:0] max_minor;
    logic       strict;
  } cfg_t;

  typedef struct packed {
    logic        ends_message;
    logic [31:0] req_tag;
    logic [31:0] body_len;
    logic [7:0]  msg_kind;
    logic        frag_follow;
    logic        little_end;
    logic [7:0]  version_minor;
    event_t      event_res;
  } res_t;

endpackage

`default_nettype wire

@@ src/ghd_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// GIOP header deframer configuration registers
// Holds the minor version limit and the strict flags switch.
// ---------------------------------------------------------------------------
`default_nettype none

module ghd_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ghd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ghd_pkg::CFG_DATA_W-1:0] cfg_data,
  output ghd_pkg::cfg_t                       cfg
);
  import ghd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_minor <= 8'd2;
      cfg.strict    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_MINOR: cfg.max_minor <= cfg_data[7:0];
        REG_STRICT:    cfg.strict    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/ghd_parser.sv @@
// ---------------------------------------------------------------------------
// GIOP header deframer parser
// Input word register, header/payload state and one-step result decode.
// ---------------------------------------------------------------------------
`default_nettype none

module ghd_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ghd_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          out_space,
  output logic               res_valid,
  output ghd_pkg::res_t      res
);
  import ghd_pkg::*;

  logic        byte_full;
  logic [7:0]  byte_reg;
  logic        step;

  phase_t      phase, phase_next;
  logic [3:0]  cnt, cnt_next, cnt_inc;
  logic [7:0]  minor, minor_next;
  logic [1:0]  flags, flags_next;
  logic [7:0]  mtype, mtype_next;
  logic [31:0] size_acc, size_next, size_shift;
  logic [31:0] remaining, remaining_next, rem_dec;
  logic [31:0] id_acc, id_next, id_shift;
  logic        hit;
  res_t        res_val;

  assign step     = byte_full && out_space;
  assign in_ready = !byte_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_full <= 1'b0;
    end else if (in_ready) begin
      byte_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      cnt       <= '0;
      minor     <= '0;
      flags     <= '0;
      mtype     <= '0;
      size_acc  <= '0;
      remaining <= '0;
      id_acc    <= '0;
    end else if (step) begin
      phase     <= phase_next;
      cnt       <= cnt_next;
      minor     <= minor_next;
      flags     <= flags_next;
      mtype     <= mtype_next;
      size_acc  <= size_next;
      remaining <= remaining_next;
      id_acc    <= id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= step && hit;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_val;
  end

  always_comb begin
    phase_next     = phase;
    cnt_next       = cnt;
    minor_next     = minor;
    flags_next     = flags;
    mtype_next     = mtype;
    size_next      = size_acc;
    remaining_next = remaining;
    id_next        = id_acc;
    hit            = 1'b0;
    rem_dec        = remaining - 32'd1;
    cnt_inc        = cnt + 4'd1;
    size_shift     = flags[0] ? (size_acc | ({24'd0, byte_reg} << {cnt[1:0], 3'b000}))
                              : {size_acc[23:0], byte_reg};
    id_shift       = flags[0] ? (id_acc | ({24'd0, byte_reg} << {cnt[1:0], 3'b000}))
                              : {id_acc[23:0], byte_reg};
    res_val               = '0;
    res_val.version_minor = minor;
    res_val.little_end    = flags[0];
    res_val.frag_follow   = flags[1];
    res_val.msg_kind      = mtype;
    res_val.body_len      = size_acc;
    res_val.event_res     = EV_HDR_OK;

    case (phase)
      PH_REQID: begin
        remaining_next = rem_dec;
        id_next        = id_shift;
        cnt_next       = cnt_inc;
        if (cnt_inc >= ID_BYTES) begin
          cnt_next             = '0;
          phase_next           = (rem_dec == 32'd0) ? PH_HEADER : PH_PAYLOAD;
          hit                  = 1'b1;
          res_val.event_res    = EV_REQ_ID;
          res_val.req_tag      = id_shift;
          res_val.ends_message = (rem_dec == 32'd0);
        end
      end
      PH_PAYLOAD: begin
        remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next           = PH_HEADER;
          cnt_next             = '0;
          hit                  = 1'b1;
          res_val.event_res    = EV_MSG_END;
          res_val.ends_message = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HEADER;
        cnt_next   = cnt_inc;
        case (cnt)
          4'd0, 4'd1, 4'd2, 4'd3: begin
            if (byte_reg != MAGIC[cnt[1:0]]) begin
              hit               = 1'b1;
              res_val           = '0;
              res_val.event_res = EV_BAD_MAGIC;
              cnt_next          = '0;
            end
          end
          4'd4: begin
            if (byte_reg != GIOP_MAJOR) begin
              hit               = 1'b1;
              res_val           = '0;
              res_val.event_res = EV_BAD_VERSION;
              cnt_next          = '0;
            end
          end
          4'd5: begin
            if (byte_reg > cfg.max_minor) begin
              hit               = 1'b1;
              res_val           = '0;
              res_val.event_res = EV_BAD_VERSION;
              cnt_next          = '0;
            end else begin
              minor_next = byte_reg;
            end
          end
          4'd6: begin
            if (minor == 8'd0) begin
              if (cfg.strict && byte_reg > 8'd1) begin
                hit               = 1'b1;
                res_val           = '0;
                res_val.event_res = EV_BAD_FLAGS;
                cnt_next          = '0;
              end else begin
                flags_next = {1'b0, byte_reg[0]};
              end
            end else begin
              if (cfg.strict && (byte_reg & FLAG_RSVD) != 8'd0) begin
                hit               = 1'b1;
                res_val           = '0;
                res_val.event_res = EV_BAD_FLAGS;
                cnt_next          = '0;
              end else begin
                flags_next = byte_reg[1:0];
              end
            end
          end
          4'd7: begin
            mtype_next = byte_reg;
            size_next  = '0;
          end
          4'd8, 4'd9, 4'd10: begin
            size_next = size_shift;
          end
          HDR_LAST: begin
            size_next        = size_shift;
            cnt_next         = '0;
            id_next          = '0;
            remaining_next   = size_shift;
            hit              = 1'b1;
            res_val.body_len = size_shift;
            if (size_shift == 32'd0) begin
              phase_next           = PH_HEADER;
              res_val.ends_message = 1'b1;
            end else if (flags[1] && minor == FRAG_MINOR && size_shift >= 32'd4) begin
              phase_next = PH_REQID;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
          default: ;
        endcase
      end
    endcase
  end

`ifndef SYNTHESIS
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD || phase == PH_REQID) |-> remaining != 32'd0)
    else $error("payload phase with nothing left to count");

  a_reqid_cnt: assert property (@(posedge clk) disable iff (rst)
    phase == PH_REQID |-> cnt < ID_BYTES)
    else $error("request id byte count out of range");

  a_hdr_cnt: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> cnt <= HDR_LAST)
    else $error("header byte count out of range");

  a_res_step: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(step))
    else $error("result without a processed word");
`endif

endmodule

`default_nettype wire

@@ src/ghd_out_fifo.sv @@
// ---------------------------------------------------------------------------
// GIOP header deframer result buffer
// Four-entry queue between the parser and the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ghd_out_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ghd_pkg::res_t push_data,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ghd_pkg::res_t      out_data
);
  import ghd_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  // leave room for the result already on its way in
  assign space     = ((count + {2'b0, push}) < 3'd4);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count < 3'd4)
    else $error("push into a full result buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result buffer count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> count == $past(count) + {2'b0, $past(push)} - {2'b0, $past(pop)})
    else $error("result buffer count lost track");
`endif

endmodule

`default_nettype wire

@@ src/giop_header_deframer_core.sv @@
// ---------------------------------------------------------------------------
// GIOP header deframer
// Parses a GIOP byte stream: header checks, payload count, fragment id.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one stream byte per word in s_tdata. m_* carries one event
//   per word: m_tuser is the event code, m_tlast marks the word that closes
//   a message, m_tdata holds the header fields and the request id.
//   cfg_* writes the minor version limit (index 0) and the strict flags
//   switch (index 1); cfg_ready is always high. Write only while idle.
// Path: an accepted byte waits in the parser input register, is parsed when
//   the result buffer has room, and its event, if any, is registered in the
//   parser and then written into the result buffer before it can be taken.
// Throughput: one byte per cycle while the result buffer has room, set by
//   the state update of the parser between its input register and the result buffer.
// Stall: a four-entry result buffer, counted together with the event on its
//   way in, keeps input flowing while events wait; when it has no room left
//   the parser holds its byte and s_tready drops.
// Reset: rst is synchronous; the parser hunts for a header, the buffer
//   empties and the registers return to minor limit 2, strict flags on.
// ---------------------------------------------------------------------------
`default_nettype none

module giop_header_deframer_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [7:0] data_byte
  input  wire logic [7:0]                     s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [7:0] version_minor, [8] little_end, [9] frag_follow,
  // [17:10] msg_kind, [49:18] body_len, [81:50] req_tag, zero above
  output logic [ghd_pkg::TDATA_W-1:0]         m_tdata,
  // [2:0] event_res
  output logic [2:0]                          m_tuser,
  // ends_message
  output logic                                m_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ghd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ghd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ghd_pkg::*;

  cfg_t cfg;
  logic res_valid;
  res_t res;
  logic space;
  res_t out_res;

  ghd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ghd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .out_space (space),
    .res_valid (res_valid),
    .res       (res)
  );

  ghd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {6'd0,
                    out_res.req_tag,
                    out_res.body_len,
                    out_res.msg_kind,
                    out_res.frag_follow,
                    out_res.little_end,
                    out_res.version_minor};
  assign m_tuser = 3'(out_res.event_res);
  assign m_tlast = out_res.ends_message;

endmodule

`default_nettype wire

@@ tb/tb_giop_header_deframer_core.sv @@
// ---------------------------------------------------------------------------
// GIOP header deframer testbench
// Streams GIOP traffic into the deframer one byte per word: well-formed
// messages with random content, fragment headers with request ids, broken
// headers and line noise, under several minor-version and strict-flag
// settings. A byte-level parser model in the testbench predicts every event,
// and each event word is checked field by field in order. Both stream sides
// idle at random, and one long receiver hold backs the block up to its input.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_giop_header_deframer_core;

  timeunit 1ns;
  timeprecision 1ps;

  import ghd_pkg::*;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_RARE,
    RDY_OFTEN
  } rdy_pat_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [7:0]              s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [TDATA_W-1:0]      m_tdata;
  logic [2:0]              m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // parser model state and register copies
  phase_t      pr_phase = PH_HEADER;
  logic [3:0]  pr_count = '0;
  logic [7:0]  pr_minor = '0;
  logic [1:0]  pr_flags = '0;
  logic [7:0]  pr_type = '0;
  logic [31:0] pr_size = '0;
  logic [31:0] pr_left = '0;
  logic [31:0] pr_reqid = '0;
  logic [7:0]  lim_minor = 8'd2;
  logic        strict_on = 1'b1;

  logic [7:0]  stream_bytes[$];
  res_t        events_due[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatches = 0;

  bit          word_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          want_hold = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  rdy_pat_t    pat = RDY_ALWAYS;
  int unsigned pat_left = 0;

  giop_header_deframer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic res_t header_view(event_t code, logic [31:0] id, logic ends);
    res_t r;
    r.event_res     = code;
    r.version_minor = pr_minor;
    r.little_end    = pr_flags[0];
    r.frag_follow   = pr_flags[1];
    r.msg_kind      = pr_type;
    r.body_len      = pr_size;
    r.req_tag       = id;
    r.ends_message  = ends;
    return r;
  endfunction

  function automatic res_t header_fault(event_t code);
    res_t r;
    r = res_t'(0);
    r.event_res = code;
    pr_count = '0;
    pr_phase = PH_HEADER;
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    logic [3:0] n;
    logic       ends;
    r = res_t'(0);
    if (pr_phase != PH_HEADER) begin
      pr_left = pr_left - 32'd1;
      if (pr_phase == PH_REQID) begin
        if (pr_flags[0]) begin
          pr_reqid = pr_reqid | (32'(b) << {pr_count[1:0], 3'b000});
        end else begin
          pr_reqid = {pr_reqid[23:0], b};
        end
        pr_count = pr_count + 4'd1;
        if (pr_count >= ID_BYTES) begin
          ends = (pr_left == 0);
          pr_count = '0;
          pr_phase = ends ? PH_HEADER : PH_PAYLOAD;
          r = header_view(EV_REQ_ID, pr_reqid, ends);
          return 1'b1;
        end
        return 1'b0;
      end
      if (pr_left == 0) begin
        pr_phase = PH_HEADER;
        pr_count = '0;
        r = header_view(EV_MSG_END, '0, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    n = pr_count;
    if (n < 4) begin
      if (b != MAGIC[n[1:0]]) begin
        r = header_fault(EV_BAD_MAGIC);
        return 1'b1;
      end
    end else if (n == 4) begin
      if (b != GIOP_MAJOR) begin
        r = header_fault(EV_BAD_VERSION);
        return 1'b1;
      end
    end else if (n == 5) begin
      if (b > lim_minor) begin
        r = header_fault(EV_BAD_VERSION);
        return 1'b1;
      end
      pr_minor = b;
    end else if (n == 6) begin
      if (pr_minor == 0) begin
        if (strict_on && b > 1) begin
          r = header_fault(EV_BAD_FLAGS);
          return 1'b1;
        end
        pr_flags = {1'b0, b[0]};
      end else begin
        if (strict_on && (b & FLAG_RSVD) != 0) begin
          r = header_fault(EV_BAD_FLAGS);
          return 1'b1;
        end
        pr_flags = b[1:0];
      end
    end else if (n == 7) begin
      pr_type = b;
      pr_size = '0;
    end else begin
      if (pr_flags[0]) begin
        pr_size = pr_size | (32'(b) << {n[1:0], 3'b000});
      end else begin
        pr_size = {pr_size[23:0], b};
      end
      if (n == HDR_LAST) begin
        pr_count = '0;
        pr_reqid = '0;
        pr_left = pr_size;
        if (pr_size == 0) begin
          pr_phase = PH_HEADER;
          r = header_view(EV_HDR_OK, '0, 1'b1);
        end else begin
          pr_phase = (pr_flags[1] && pr_minor == FRAG_MINOR && pr_size >= 32'(ID_BYTES)) ?
                     PH_REQID : PH_PAYLOAD;
          r = header_view(EV_HDR_OK, '0, 1'b0);
        end
        return 1'b1;
      end
    end
    pr_count = n + 4'd1;
    return 1'b0;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("ev=%0d minor=%02h bo=%0b mf=%0b type=%02h size=%08h id=%08h last=%0b",
                     r.event_res, r.version_minor, r.little_end, r.frag_follow,
                     r.msg_kind, r.body_len, r.req_tag, r.ends_message);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void queue_lead(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      push_byte(i < 4 ? MAGIC[i[1:0]] : GIOP_MAJOR);
    end
  endfunction

  function automatic void queue_header(input logic [7:0] minor, flags, mtype,
                                       input logic [31:0] len);
    queue_lead(5);
    push_byte(minor);
    push_byte(flags);
    push_byte(mtype);
    for (int i = 0; i < 4; i++) begin
      push_byte(flags[0] ? len[8*i +: 8] : len[8*(3-i) +: 8]);
    end
  endfunction

  function automatic void queue_body(input int unsigned n, input int fill);
    for (int unsigned i = 0; i < n; i++) begin
      push_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
  endfunction

  function automatic void queue_traffic();
    int unsigned kind;
    int unsigned p;
    int unsigned len;
    logic [7:0]  minor;
    logic [7:0]  flags;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      queue_body($urandom_range(1, 6), -1);
    end else if (kind == 1) begin
      p = $urandom_range(0, 6);
      if (p == 5 && lim_minor == 8'hFF) p = 4;
      if (p == 6 && !strict_on) p = 3;
      if (p >= 1 && p <= 4 && $urandom_range(0, 3) == 0) begin
        queue_lead(p);
      end else begin
        queue_lead(p > 5 ? 5 : p);
        case (p)
          0, 1, 2, 3: push_byte(MAGIC[p[1:0]] ^ 8'($urandom_range(1, 255)));
          4: push_byte(GIOP_MAJOR ^ 8'($urandom_range(1, 255)));
          5: push_byte(8'($urandom_range(int'(lim_minor) + 1, 255)));
          default: begin
            minor = 8'($urandom_range(0, lim_minor));
            push_byte(minor);
            push_byte(minor == 0 ? 8'($urandom_range(2, 255)) :
                      {6'($urandom_range(1, 63)), 2'($urandom_range(0, 3))});
          end
        endcase
      end
    end else begin
      if (lim_minor >= FRAG_MINOR && $urandom_range(0, 2) == 0) begin
        minor = FRAG_MINOR;
      end else begin
        minor = 8'($urandom_range(0, lim_minor));
      end
      if (!strict_on) begin
        flags = 8'($urandom_range(0, 255));
      end else if (minor == 0) begin
        flags = 8'($urandom_range(0, 1));
      end else begin
        flags = 8'($urandom_range(0, 3));
      end
      if (minor == FRAG_MINOR && $urandom_range(0, 1) == 1) flags[1] = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      queue_header(minor, flags, 8'($urandom_range(0, 255)), len);
      queue_body(len, -1);
    end
  endfunction

  task automatic fill_random(input int unsigned n);
    int unsigned goal;
    goal = bytes_queued + n;
    while (bytes_queued < goal) queue_traffic();
  endtask

  task automatic settle();
    @(posedge clk);
    while (stream_bytes.size() != 0 || s_tvalid || events_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAX_MINOR) begin
      lim_minor = val;
    end else if (idx == REG_STRICT) begin
      strict_on = val[0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : take_byte
    res_t ev;
    word_taken = s_tvalid && s_tready;
    if (word_taken && deframe_byte(s_tdata, ev)) events_due.push_back(ev);
  end

  always @(negedge clk) begin : feed_bytes
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (stream_bytes.size() != 0) begin
        s_tdata  <= stream_bytes.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap_left = 0;
            6, 7, 8: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 20);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drain_events
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      m_tready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat = rdy_pat_t'($urandom_range(0, 3));
        pat_left = $urandom_range(8, 64);
      end
      pat_left--;
      case (pat)
        RDY_ALWAYS: m_tready <= 1'b1;
        RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RDY_RARE:   m_tready <= ($urandom_range(0, 7) == 0);
        default:    m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_events
    res_t                 got;
    res_t                 want;
    logic [TDATA_W-83:0]  pad;
    if (!rst && m_tvalid && m_tready) begin
      got.event_res     = event_t'(m_tuser);
      got.version_minor = m_tdata[7:0];
      got.little_end    = m_tdata[8];
      got.frag_follow   = m_tdata[9];
      got.msg_kind      = m_tdata[17:10];
      got.body_len      = m_tdata[49:18];
      got.req_tag       = m_tdata[81:50];
      got.ends_message  = m_tlast;
      pad               = m_tdata[TDATA_W-1:82];
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event word: %s", show(got));
      end else begin
        want = events_due.pop_front();
        if (got.event_res !== want.event_res || got.version_minor !== want.version_minor ||
            got.little_end !== want.little_end || got.frag_follow !== want.frag_follow ||
            got.msg_kind !== want.msg_kind ||
            got.body_len !== want.body_len ||
            got.req_tag !== want.req_tag || got.ends_message !== want.ends_message ||
            pad !== '0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("event mismatch: want %s", show(want));
            $display("                got  %s pad=%0h", show(got), pad);
          end
        end
      end
    end
  end

  initial begin : run
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero size, fragments with id at both extremes, plain payloads, 1.0 little endian
    queue_header(8'd2, 8'h00, 8'h00, 32'd0);
    queue_header(8'd2, 8'h03, 8'h07, 32'd6);
    queue_body(6, 8'hFF);
    queue_header(8'd2, 8'h02, 8'h01, 32'd4);
    queue_body(4, 8'h00);
    queue_header(8'd1, 8'h00, 8'h05, 32'd3);
    queue_body(3, -1);
    queue_header(8'd0, 8'h01, 8'h02, 32'd1);
    queue_body(1, -1);
    queue_header(8'd2, 8'h02, 8'h03, 32'd3);
    queue_body(3, -1);
    queue_header(8'd1, 8'h00, 8'h10, 32'h0000_0105);
    queue_body(261, -1);
    queue_header(8'd2, 8'h01, 8'h11, 32'h0000_0102);
    queue_body(258, -1);
    // bad magic, bad major, minor over limit, reserved flags, 1.0 flags above one
    queue_lead(1);
    push_byte(8'h58);
    queue_lead(4);
    push_byte(8'h02);
    queue_lead(5);
    push_byte(8'h03);
    queue_lead(5);
    push_byte(8'h01);
    push_byte(8'h04);
    queue_lead(5);
    push_byte(8'h00);
    push_byte(8'h02);
    fill_random(250);

    settle();
    write_reg(REG_MAX_MINOR, 8'd0);
    write_reg(REG_STRICT, 8'd0);
    fill_random(250);

    settle();
    write_reg(REG_MAX_MINOR, 8'd255);
    write_reg(REG_STRICT, 8'd1);
    fill_random(250);

    settle();
    write_reg(REG_MAX_MINOR, 8'd1);
    write_reg(REG_STRICT, 8'd0);
    fill_random(200);

    // hold the event side while noise keeps the parser producing errors
    settle();
    write_reg(REG_MAX_MINOR, 8'd2);
    write_reg(REG_STRICT, 8'd1);
    want_hold = 1'b1;
    wait (hold_done);
    queue_body(120, -1);
    fill_random(200);

    settle();
    write_reg(REG_MAX_MINOR, 8'd255);
    write_reg(REG_STRICT, 8'd0);
    queue_header(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);

    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
